// File: sv/iafp_pkg.sv
package iafp_pkg;

  // Frame length in bytes, header included, checksum byte last
  localparam int FRAME_BYTES = 11;
  // Window cells: the checksum byte is never stored, it is checked on arrival
  localparam int CELLS       = FRAME_BYTES - 1;
  localparam int FILL_W      = $clog2(FRAME_BYTES);

  localparam logic [7:0] HDR0 = 8'h55;
  localparam logic [7:0] HDR1 = 8'h53;

  // Byte positions of the big-endian angle words
  localparam int ROLL_POS  = 3;
  localparam int PITCH_POS = 5;
  localparam int YAW_POS   = 7;

  // Input operation codes
  localparam logic OP_BYTE  = 1'b0;
  localparam logic OP_RESET = 1'b1;

  // Per-cell control, priority clear over shift over load
  typedef struct packed {
    logic clear;
    logic shift;
    logic load;
  } cell_ctl_t;

  // Result waiting in the output queue; yaw is formed at the head
  typedef struct packed {
    logic signed [15:0] roll;
    logic signed [15:0] pitch;
    logic signed [32:0] unwrapped;
    logic signed [31:0] offset;
  } result_t;

endpackage

// File: sv/iafp_if.sv
interface iafp_in_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [7:0] data_byte;

  modport source (output valid, output op, output data_byte, input ready);
  modport sink   (input valid, input op, input data_byte, output ready);
endinterface

interface iafp_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] roll;
  logic signed [15:0] pitch;
  logic signed [32:0] yaw;

  modport source (output valid, output roll, output pitch, output yaw, input ready);
  modport sink   (input valid, input roll, input pitch, input yaw, output ready);
endinterface

// File: sv/iafp_cell.sv
module iafp_cell
  import iafp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  cell_ctl_t  ctl,
  input  logic [7:0] load_byte,
  input  logic [7:0] neighbor_byte,
  output logic [7:0] cell_byte
);

  logic [7:0] byte_r;
  logic [7:0] byte_nxt;

  // Pick clear, shift from the neighbor, or load the new byte
  always_comb begin
    priority if (ctl.clear) begin
      byte_nxt = 8'h00;
    end else if (ctl.shift) begin
      byte_nxt = neighbor_byte;
    end else if (ctl.load) begin
      byte_nxt = load_byte;
    end else begin
      byte_nxt = byte_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_r <= 8'h00;
    end else begin
      byte_r <= byte_nxt;
    end
  end

  assign cell_byte = byte_r;

endmodule

// File: sv/iafp_out_queue.sv
module iafp_out_queue
  import iafp_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  result_t push_data,
  input  logic    pop_ready,
  output logic    head_valid,
  output result_t head_data,
  output logic    has_room
);

  result_t    entry_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] count_r;
  logic [1:0] count_nxt;
  logic       pop;

  assign head_valid = (count_r != 2'd0);
  assign has_room   = (count_r != 2'd2);
  assign pop        = head_valid && pop_ready;
  assign head_data  = entry_r[rd_ptr_r];

  // Track occupancy
  always_comb begin
    unique case ({push, pop})
      2'b10:   count_nxt = count_r + 2'd1;
      2'b01:   count_nxt = count_r - 2'd1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
    end
  end

  // Store the pushed result
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// File: sv/imu_angle_frame_parser_top.sv
// Angle-frame parser for a serial inertial sensor. Each input transaction carries
// either a received byte or a reset-angles command; bytes fill a window of
// FRAME_BYTES bytes held in a row of byte cells, and a full window starting 0x55 0x53
// whose 8-bit sum of the leading bytes equals the last byte yields one output
// transaction with roll, pitch and unwrapped, offset-corrected yaw (units of
// 180/32768 degree). A bad window drops its oldest byte by shifting the cell row.
// One input transaction is taken every cycle while the output queue has room;
// the checksum is kept as a running sum, so the frame check is one compare. A
// result is pushed into a two-entry output queue when the closing byte is taken;
// input stalls only when both entries hold untaken results.
module imu_angle_frame_parser_top
  import iafp_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  iafp_in_if.sink    in_ch,
  iafp_out_if.source out_ch
);

  logic [7:0]        cell_bytes [CELLS];
  cell_ctl_t         cell_ctl   [CELLS];

  logic [FILL_W-1:0] fill_r;
  logic [FILL_W-1:0] fill_nxt;
  logic [7:0]        sum_r;
  logic [7:0]        sum_nxt;
  logic [15:0]       prev_yaw_r;
  logic [15:0]       prev_yaw_nxt;
  logic [15:0]       turn_r;
  logic [15:0]       turn_nxt;
  logic [31:0]       offset_r;
  logic [31:0]       offset_nxt;

  logic              accept;
  logic              byte_acc;
  logic              reset_acc;
  logic              closing;
  logic              frame_ok;
  logic              frame_good;
  logic              frame_bad;
  logic              queue_room;
  logic              head_valid;
  result_t           push_data;
  result_t           head_data;

  logic [15:0]        raw_yaw;
  logic signed [17:0] yaw_step;
  logic [15:0]        frame_turn;

  assign accept    = in_ch.valid && in_ch.ready;
  assign byte_acc  = accept && (in_ch.op == OP_BYTE);
  assign reset_acc = accept && (in_ch.op == OP_RESET);
  assign closing   = (fill_r == FILL_W'(FRAME_BYTES - 1));

  // Check header and running checksum against the arriving last byte
  assign frame_ok   = (cell_bytes[0] == HDR0) && (cell_bytes[1] == HDR1)
                      && (sum_r == in_ch.data_byte);
  assign frame_good = byte_acc && closing && frame_ok;
  assign frame_bad  = byte_acc && closing && !frame_ok;

  // Drive the cell row: load at the fill position, shift on a bad window, clear on a good frame
  always_comb begin
    for (int i = 0; i < CELLS; i++) begin
      cell_ctl[i].clear = frame_good;
      cell_ctl[i].shift = frame_bad;
      cell_ctl[i].load  = byte_acc && !closing && (fill_r == FILL_W'(i));
    end
  end

  genvar g;
  generate
    for (g = 0; g < CELLS; g++) begin : g_cell
      if (g == CELLS - 1) begin : g_last
        iafp_cell u_cell (
          .clk           (clk),
          .rst_n         (rst_n),
          .ctl           (cell_ctl[g]),
          .load_byte     (in_ch.data_byte),
          .neighbor_byte (in_ch.data_byte),
          .cell_byte     (cell_bytes[g])
        );
      end else begin : g_mid
        iafp_cell u_cell (
          .clk           (clk),
          .rst_n         (rst_n),
          .ctl           (cell_ctl[g]),
          .load_byte     (in_ch.data_byte),
          .neighbor_byte (cell_bytes[g+1]),
          .cell_byte     (cell_bytes[g])
        );
      end
    end
  endgenerate

  // Advance fill count and running checksum of the stored bytes
  always_comb begin
    fill_nxt = fill_r;
    sum_nxt  = sum_r;
    priority if (frame_good) begin
      fill_nxt = '0;
      sum_nxt  = 8'h00;
    end else if (frame_bad) begin
      sum_nxt = sum_r - cell_bytes[0] + in_ch.data_byte;
    end else if (byte_acc) begin
      fill_nxt = fill_r + FILL_W'(1);
      sum_nxt  = sum_r + in_ch.data_byte;
    end
  end

  // Unwrap yaw: a jump over half a turn steps the turn counter
  assign raw_yaw  = {cell_bytes[YAW_POS], cell_bytes[YAW_POS+1]};
  assign yaw_step = 18'(signed'(raw_yaw)) - 18'(signed'(prev_yaw_r));

  always_comb begin
    priority if (yaw_step > 18'sd32768) begin
      frame_turn = turn_r - 16'd1;
    end else if (yaw_step < -18'sd32768) begin
      frame_turn = turn_r + 16'd1;
    end else begin
      frame_turn = turn_r;
    end
  end

  // Update yaw state on a good frame or a reset command
  always_comb begin
    prev_yaw_nxt = prev_yaw_r;
    turn_nxt     = turn_r;
    offset_nxt   = offset_r;
    priority if (reset_acc) begin
      offset_nxt   = {turn_r, 16'h0000} + {{16{prev_yaw_r[15]}}, prev_yaw_r};
      prev_yaw_nxt = 16'h0000;
      turn_nxt     = 16'h0000;
    end else if (frame_good) begin
      prev_yaw_nxt = raw_yaw;
      turn_nxt     = frame_turn;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r     <= '0;
      sum_r      <= 8'h00;
      prev_yaw_r <= 16'h0000;
      turn_r     <= 16'h0000;
      offset_r   <= 32'h0000_0000;
    end else begin
      fill_r     <= fill_nxt;
      sum_r      <= sum_nxt;
      prev_yaw_r <= prev_yaw_nxt;
      turn_r     <= turn_nxt;
      offset_r   <= offset_nxt;
    end
  end

  // Build the result with the offset in force at frame time
  always_comb begin
    push_data.roll      = {cell_bytes[ROLL_POS], cell_bytes[ROLL_POS+1]};
    push_data.pitch     = {cell_bytes[PITCH_POS], cell_bytes[PITCH_POS+1]};
    push_data.unwrapped = {frame_turn[15], frame_turn, 16'h0000}
                          + {{17{raw_yaw[15]}}, raw_yaw};
    push_data.offset    = offset_r;
  end

  iafp_out_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (frame_good),
    .push_data  (push_data),
    .pop_ready  (out_ch.ready),
    .head_valid (head_valid),
    .head_data  (head_data),
    .has_room   (queue_room)
  );

  assign in_ch.ready  = queue_room;
  assign out_ch.valid = head_valid;
  assign out_ch.roll  = head_data.roll;
  assign out_ch.pitch = head_data.pitch;
  assign out_ch.yaw   = head_data.unwrapped - {head_data.offset[31], head_data.offset};

endmodule

// File: sv/iafp_checker.sv
module iafp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [64:0] out_payload
);

  // Hold a stalled output transaction
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_payload))
    else $error("stalled output transaction changed");

  // Drop output valid coming out of reset
  assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

  // Stall input only while results wait
  assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("input stalled with no pending result");

  // Start a result only after an input transaction
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready))
    else $error("result without input transaction");

endmodule

bind imu_angle_frame_parser_top iafp_checker u_iafp_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .out_payload ({out_ch.roll, out_ch.pitch, out_ch.yaw})
);

// File: tb/sv/imu_angle_frame_parser_top_test.sv
`timescale 1ns / 100ps

module imu_angle_frame_parser_top_test;
  import iafp_pkg::*;

  localparam int CLK_HALF      = 4;
  localparam int RESET_CYCLES  = 5;
  localparam int RANDOM_ITEMS  = 450;
  localparam int LONG_HOLD     = 150;
  localparam int DRAIN_CYCLES  = 16;
  localparam int TIMEOUT_NS    = 4_000_000;
  localparam int DIRECTED_ROWS = 25;

  typedef struct packed {
    logic signed [15:0] roll;
    logic signed [15:0] pitch;
    logic signed [32:0] yaw;
  } angles_t;

  typedef struct {
    logic       op;
    logic [7:0] data;
    bit         typed;
    angles_t    want;
  } stim_row_t;

  typedef enum int {FLAW_NONE, FLAW_SUM, FLAW_HDR, FLAW_SHORT} frame_flaw_t;
  typedef enum int {RX_OPEN, RX_LIGHT, RX_HEAVY, RX_PATTERN} rx_mode_t;

  localparam angles_t NO_ANGLES = '0;

  logic clk = 1'b0;
  logic rst_n;

  iafp_in_if  in_ch();
  iafp_out_if out_ch();

  imu_angle_frame_parser_top DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #(CLK_HALF) clk = ~clk;

  // Parser state mirrored in the bench
  logic [7:0]  frame_win [FRAME_BYTES];
  int          frame_fill;
  logic [15:0] last_raw_yaw;
  logic [15:0] yaw_turns;
  logic [31:0] yaw_zero;

  angles_t pending_angles [$];
  int      failures;
  int      items_taken;
  int      burst_left;
  bit      gaps_on;
  int      hold_count;

  // Directed frames: two noise bytes slide out ahead of frame one, frame two
  // crosses the half-turn boundary, then an angle reset captures the offset
  stim_row_t directed_rows [DIRECTED_ROWS] = '{
    '{OP_BYTE, 8'h00, 1'b0, NO_ANGLES},
    '{OP_BYTE, 8'hFF, 1'b0, NO_ANGLES},
    '{OP_BYTE, 8'h55, 1'b0, NO_ANGLES},
    '{OP_BYTE, 8'h53, 1'b0, NO_ANGLES},
    '{OP_BYTE, 8'h01, 1'b0, NO_ANGLES},
    '{OP_BYTE, 8'h7F, 1'b0, NO_ANGLES},
    '{OP_BYTE, 8'hFF, 1'b0, NO_ANGLES},
    '{OP_BYTE, 8'h80, 1'b0, NO_ANGLES},
    '{OP_BYTE, 8'h00, 1'b0, NO_ANGLES},
    '{OP_BYTE, 8'h7F, 1'b0, NO_ANGLES},
    '{OP_BYTE, 8'hFF, 1'b0, NO_ANGLES},
    '{OP_BYTE, 8'h00, 1'b0, NO_ANGLES},
    '{OP_BYTE, 8'h25, 1'b1, '{16'sh7FFF, 16'sh8000, 33'sd32767}},
    '{OP_BYTE, 8'h55, 1'b0, NO_ANGLES},
    '{OP_BYTE, 8'h53, 1'b0, NO_ANGLES},
    '{OP_BYTE, 8'h01, 1'b0, NO_ANGLES},
    '{OP_BYTE, 8'h80, 1'b0, NO_ANGLES},
    '{OP_BYTE, 8'h00, 1'b0, NO_ANGLES},
    '{OP_BYTE, 8'h7F, 1'b0, NO_ANGLES},
    '{OP_BYTE, 8'hFF, 1'b0, NO_ANGLES},
    '{OP_BYTE, 8'h80, 1'b0, NO_ANGLES},
    '{OP_BYTE, 8'h00, 1'b0, NO_ANGLES},
    '{OP_BYTE, 8'h00, 1'b0, NO_ANGLES},
    '{OP_BYTE, 8'h27, 1'b1, '{16'sh8000, 16'sh7FFF, 33'sd32768}},
    '{OP_RESET, 8'hFF, 1'b0, NO_ANGLES}
  };

  function automatic void clear_parser();
    foreach (frame_win[k]) frame_win[k] = '0;
    frame_fill   = 0;
    last_raw_yaw = '0;
    yaw_turns    = '0;
    yaw_zero     = '0;
  endfunction

  // Advance the parser by one item; return 1 with the angles on a valid frame
  function automatic bit parse_item(input logic op_i, input logic [7:0] byte_i,
                                    output angles_t res);
    logic [7:0] sum;
    longint     turns;
    longint     prev_s;
    longint     raw_s;
    longint     diff;
    longint     unwrapped;
    res = '0;
    if (op_i == OP_RESET) begin
      turns    = $signed(yaw_turns);
      prev_s   = $signed(last_raw_yaw);
      yaw_zero = 32'(turns * 65536 + prev_s);
      yaw_turns    = '0;
      last_raw_yaw = '0;
      return 1'b0;
    end
    frame_win[frame_fill] = byte_i;
    frame_fill++;
    if (frame_fill < FRAME_BYTES) return 1'b0;
    sum = '0;
    for (int k = 0; k < FRAME_BYTES - 1; k++) sum += frame_win[k];
    // Drop the oldest byte of a bad window
    if (frame_win[0] != HDR0 || frame_win[1] != HDR1 || sum != frame_win[FRAME_BYTES-1]) begin
      for (int k = 0; k < FRAME_BYTES - 1; k++) frame_win[k] = frame_win[k+1];
      frame_win[FRAME_BYTES-1] = '0;
      frame_fill = FRAME_BYTES - 1;
      return 1'b0;
    end
    res.roll  = {frame_win[ROLL_POS], frame_win[ROLL_POS+1]};
    res.pitch = {frame_win[PITCH_POS], frame_win[PITCH_POS+1]};
    // Unwrap yaw: a step over half a turn moves the turn counter
    raw_s  = $signed({frame_win[YAW_POS], frame_win[YAW_POS+1]});
    prev_s = $signed(last_raw_yaw);
    diff   = raw_s - prev_s;
    if (diff > 32768) yaw_turns = yaw_turns - 16'd1;
    else if (diff < -32768) yaw_turns = yaw_turns + 16'd1;
    last_raw_yaw = {frame_win[YAW_POS], frame_win[YAW_POS+1]};
    turns     = $signed(yaw_turns);
    unwrapped = turns * 65536 + raw_s;
    res.yaw   = 33'(unwrapped - longint'($signed(yaw_zero)));
    foreach (frame_win[k]) frame_win[k] = '0;
    frame_fill = 0;
    return 1'b1;
  endfunction

  // Offer one transaction in bursts with random gaps, then record its outcome
  task automatic send_item(input logic op_i, input logic [7:0] byte_i,
                           input bit typed, input angles_t typed_res);
    int      gap;
    angles_t res;
    bit      hit;
    if (gaps_on && burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 12) : $urandom_range(0, 2);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    if (burst_left > 0) burst_left--;
    in_ch.valid     <= 1'b1;
    in_ch.op        <= op_i;
    in_ch.data_byte <= byte_i;
    do @(posedge clk); while (!in_ch.ready);
    items_taken++;
    hit = parse_item(op_i, byte_i, res);
    if (typed) pending_angles.push_back(typed_res);
    else if (hit) pending_angles.push_back(res);
  endtask

  // Pick a yaw that exercises small steps, wraps and exact half turns
  function automatic logic [15:0] pick_yaw();
    case ($urandom_range(0, 3))
      0: return 16'($urandom);
      1: return last_raw_yaw + 16'($urandom_range(0, 4000)) - 16'd2000;
      2: return last_raw_yaw ^ 16'h8000;
      default: begin
        case ($urandom_range(0, 3))
          0: return 16'h7FFF;
          1: return 16'h8000;
          2: return 16'h0000;
          default: return 16'hFFFF;
        endcase
      end
    endcase
  endfunction

  // Build one angle frame, optionally damaged, and send its bytes
  task automatic send_frame(input logic [15:0] roll_i, input logic [15:0] pitch_i,
                            input logic [15:0] yaw_i, input frame_flaw_t flaw);
    logic [7:0] fr [FRAME_BYTES];
    logic [7:0] sum;
    int         n;
    foreach (fr[k]) fr[k] = 8'($urandom);
    fr[0] = HDR0;
    fr[1] = HDR1;
    {fr[ROLL_POS], fr[ROLL_POS+1]}   = roll_i;
    {fr[PITCH_POS], fr[PITCH_POS+1]} = pitch_i;
    {fr[YAW_POS], fr[YAW_POS+1]}     = yaw_i;
    sum = '0;
    for (int k = 0; k < FRAME_BYTES - 1; k++) sum += fr[k];
    fr[FRAME_BYTES-1] = sum;
    n = FRAME_BYTES;
    case (flaw)
      FLAW_SUM:   fr[FRAME_BYTES-1] ^= 8'(1 << $urandom_range(0, 7));
      FLAW_HDR:   fr[$urandom_range(0, 1)] ^= 8'(1 << $urandom_range(0, 7));
      FLAW_SHORT: n = $urandom_range(1, FRAME_BYTES - 1);
      default: ;
    endcase
    for (int k = 0; k < n; k++) send_item(OP_BYTE, fr[k], 1'b0, NO_ANGLES);
  endtask

  // Hold the sender until every expected result has come back
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (pending_angles.size() != 0);
  endtask

  // Stimulus
  initial begin
    int  pick;
    bit  hold_done;
    bit  drain_done;
    int  last_count;
    rst_n           = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.op        = OP_BYTE;
    in_ch.data_byte = '0;
    hold_count      = 0;
    failures        = 0;
    items_taken     = 0;
    burst_left      = 0;
    gaps_on         = 1'b1;
    hold_done       = 1'b0;
    drain_done      = 1'b0;
    clear_parser();
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // Walk the directed table
    foreach (directed_rows[i])
      send_item(directed_rows[i].op, directed_rows[i].data,
                directed_rows[i].typed, directed_rows[i].want);
    drain_results();

    // Random frames, damaged frames, angle resets and line noise
    last_count = items_taken + RANDOM_ITEMS;
    while (items_taken < last_count) begin
      if (!hold_done && items_taken > last_count - 300) begin
        // Stall the receiver and stream back-to-back good frames into it
        hold_done  = 1'b1;
        hold_count <= hold_count + 1;
        gaps_on    = 1'b0;
        repeat (5) send_frame(16'($urandom), 16'($urandom), pick_yaw(), FLAW_NONE);
        gaps_on    = 1'b1;
      end else if (!drain_done && items_taken > last_count - 150) begin
        drain_done = 1'b1;
        drain_results();
      end
      pick = $urandom_range(0, 99);
      if (pick < 68) begin
        send_frame(16'($urandom), 16'($urandom), pick_yaw(), FLAW_NONE);
      end else if (pick < 80) begin
        send_frame(16'($urandom), 16'($urandom), pick_yaw(),
                   frame_flaw_t'($urandom_range(FLAW_SUM, FLAW_SHORT)));
      end else if (pick < 88) begin
        send_item(OP_RESET, 8'($urandom), 1'b0, NO_ANGLES);
      end else begin
        repeat ($urandom_range(1, 6)) begin
          case ($urandom_range(0, 3))
            0:       send_item(OP_BYTE, HDR0, 1'b0, NO_ANGLES);
            1:       send_item(OP_BYTE, HDR1, 1'b0, NO_ANGLES);
            default: send_item(OP_BYTE, 8'($urandom), 1'b0, NO_ANGLES);
          endcase
        end
      end
    end

    // Let the last results drain, then report
    in_ch.valid <= 1'b0;
    while (pending_angles.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (failures == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Receiver: stall pattern of its own, plus a long hold on request
  initial begin
    rx_mode_t mode;
    int       mode_left;
    int       hold_left;
    int       hold_seen;
    int       phase;
    out_ch.ready = 1'b0;
    mode      = RX_OPEN;
    mode_left = 0;
    hold_left = 0;
    hold_seen = 0;
    phase     = 0;
    forever begin
      @(posedge clk);
      if (hold_seen != hold_count) begin
        hold_seen = hold_count;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode      = rx_mode_t'($urandom_range(RX_OPEN, RX_PATTERN));
          mode_left = $urandom_range(16, 160);
        end
        mode_left--;
        phase++;
        case (mode)
          RX_OPEN:  out_ch.ready <= 1'b1;
          RX_LIGHT: out_ch.ready <= ($urandom_range(0, 3) != 0);
          RX_HEAVY: out_ch.ready <= ($urandom_range(0, 3) == 0);
          default:  out_ch.ready <= ((phase % 7) < 4);
        endcase
      end
    end
  end

  // Compare each result transaction with the oldest expected angles
  always @(posedge clk) begin
    angles_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_angles.size() == 0) begin
        $error("unexpected result: roll %0d pitch %0d yaw %0d",
               out_ch.roll, out_ch.pitch, out_ch.yaw);
        failures++;
      end else begin
        want = pending_angles.pop_front();
        if (out_ch.roll !== want.roll) begin
          $error("roll: expected %0d, got %0d", want.roll, out_ch.roll);
          failures++;
        end
        if (out_ch.pitch !== want.pitch) begin
          $error("pitch: expected %0d, got %0d", want.pitch, out_ch.pitch);
          failures++;
        end
        if (out_ch.yaw !== want.yaw) begin
          $error("yaw: expected %0d, got %0d", want.yaw, out_ch.yaw);
          failures++;
        end
      end
    end
  end

  // Bound the run
  initial begin
    #(TIMEOUT_NS);
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

// File: sim.f
sv/iafp_pkg.sv
sv/iafp_if.sv
sv/iafp_cell.sv
sv/iafp_out_queue.sv
sv/imu_angle_frame_parser_top.sv
sv/iafp_checker.sv
tb/sv/imu_angle_frame_parser_top_test.sv
